// ===== rtl/lpmh_pkg.sv =====
// Shared types, constants and the drive saturation function for the lift PID
// move-and-hold controller. No dependencies.
`default_nettype none

package lpmh_pkg;

    localparam int SUM_BITS  = 40;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ANGLE_W   = 16;
    localparam int POS_W     = 24;
    localparam int ERR_W     = 17;
    localparam int DER_W     = 18;
    localparam int TICK_W    = 16;
    localparam int POWER_W   = 8;
    localparam int PHASE_W   = 2;

    localparam int TP_W      = ERR_W + 17;
    localparam int TD_W      = DER_W + 17;
    localparam int TI_W      = SUM_BITS + 17;
    localparam int TERM_EXP  = 40;
    localparam int CLAMP_W   = (TI_W > TERM_EXP + 2) ? TI_W : TERM_EXP + 2;
    localparam int ACC_W     = TERM_EXP + 3;
    localparam int FRAC_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_BAND  = 3'd5;

    localparam logic [CFG_W-1:0] SETTLE_BAND_RST = 16'd100;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic signed [ACC_W-1:0] POWER_MAX = ACC_W'(127);
    localparam logic signed [ACC_W-1:0] POWER_MIN = -POWER_MAX;

    typedef struct packed {
        logic [CFG_W-1:0] target_angle;
        logic [CFG_W-1:0] gain_p;
        logic [CFG_W-1:0] gain_i;
        logic [CFG_W-1:0] gain_d;
        logic [CFG_W-1:0] tick_limit;
        logic [CFG_W-1:0] settle_band;
    } cfg_t;

    function automatic logic signed [POWER_W-1:0] sat_power(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        begin
            if (v > POWER_MAX) begin
                c = POWER_MAX;
            end else if (v < POWER_MIN) begin
                c = POWER_MIN;
            end else begin
                c = v;
            end
            return c[POWER_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lpmh_cfg_regs.sv =====
// Configuration register file for the lift PID controller.
// Depends on lpmh_pkg.
`default_nettype none

module lpmh_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lpmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpmh_pkg::CFG_W-1:0]     cfg_wr_data,
    output lpmh_pkg::cfg_t                     cfg
);

    lpmh_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_angle <= '0;
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.tick_limit   <= '0;
            cfg_reg.settle_band  <= lpmh_pkg::SETTLE_BAND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lpmh_pkg::REG_TARGET_ANGLE: cfg_reg.target_angle <= cfg_wr_data;
                lpmh_pkg::REG_GAIN_P:       cfg_reg.gain_p       <= cfg_wr_data;
                lpmh_pkg::REG_GAIN_I:       cfg_reg.gain_i       <= cfg_wr_data;
                lpmh_pkg::REG_GAIN_D:       cfg_reg.gain_d       <= cfg_wr_data;
                lpmh_pkg::REG_TICK_LIMIT:   cfg_reg.tick_limit   <= cfg_wr_data;
                lpmh_pkg::REG_SETTLE_BAND:  cfg_reg.settle_band  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/lpmh_pid_calc.sv =====
// Combinational PID step: angle error, derivative, saturated integral and
// the Q31.12 drive sum. Depends on lpmh_pkg.
`default_nettype none

module lpmh_pid_calc (
    input  wire lpmh_pkg::cfg_t                       cfg,
    input  wire logic        [lpmh_pkg::ANGLE_W-1:0]  angle,
    input  wire logic signed [lpmh_pkg::ERR_W-1:0]    last_error,
    input  wire logic signed [lpmh_pkg::SUM_BITS-1:0] error_sum,
    output logic signed      [lpmh_pkg::ERR_W-1:0]    err,
    output logic signed      [lpmh_pkg::SUM_BITS-1:0] sum_sat,
    output logic signed      [lpmh_pkg::POWER_W-1:0]  power
);

    localparam int SB = lpmh_pkg::SUM_BITS;
    localparam int CW = lpmh_pkg::CLAMP_W;
    localparam int AW = lpmh_pkg::ACC_W;

    localparam logic signed [CW-1:0] TERM_POS =
        {{(CW - lpmh_pkg::TERM_EXP - 1){1'b0}}, 1'b1, {lpmh_pkg::TERM_EXP{1'b0}}};
    localparam logic signed [CW-1:0] TERM_NEG = -TERM_POS;
    localparam logic signed [SB-1:0] SUM_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SUM_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [AW-1:0] ROUND_ADJ = AW'((1 << lpmh_pkg::FRAC_W) - 1);

    logic signed [lpmh_pkg::DER_W-1:0] der;
    logic signed [SB:0]                sum_wide;
    logic signed [16:0]                gp_s;
    logic signed [16:0]                gi_s;
    logic signed [16:0]                gd_s;
    logic signed [lpmh_pkg::TP_W-1:0]  tp;
    logic signed [lpmh_pkg::TD_W-1:0]  td;
    logic signed [lpmh_pkg::TI_W-1:0]  ti;
    logic signed [CW-1:0]              ti_ext;
    logic signed [CW-1:0]              ti_clamp;
    logic signed [AW-1:0]              acc;
    logic signed [AW-1:0]              acc_adj;
    logic signed [AW-1:0]              quot;

    assign err = $signed({1'b0, cfg.target_angle}) - $signed({1'b0, angle});
    assign der = $signed({err[lpmh_pkg::ERR_W-1], err})
               - $signed({last_error[lpmh_pkg::ERR_W-1], last_error});

    assign sum_wide = $signed({error_sum[SB-1], error_sum}) + (SB+1)'(err);

    always_comb begin
        if (sum_wide[SB] != sum_wide[SB-1]) begin
            sum_sat = sum_wide[SB] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SB-1:0];
        end
    end

    assign gp_s = $signed({1'b0, cfg.gain_p});
    assign gi_s = $signed({1'b0, cfg.gain_i});
    assign gd_s = $signed({1'b0, cfg.gain_d});

    assign tp = gp_s * err;
    assign td = gd_s * der;
    assign ti = gi_s * sum_sat;

    // only the integral term can reach the 2^40 limit
    assign ti_ext = CW'(ti);

    always_comb begin
        if (ti_ext > TERM_POS) begin
            ti_clamp = TERM_POS;
        end else if (ti_ext < TERM_NEG) begin
            ti_clamp = TERM_NEG;
        end else begin
            ti_clamp = ti_ext;
        end
    end

    assign acc = AW'(tp) + AW'(td) + AW'(ti_clamp);

    // divide by 4096, truncating toward zero
    assign acc_adj = acc[AW-1] ? (acc + ROUND_ADJ) : acc;
    assign quot    = acc_adj >>> lpmh_pkg::FRAC_W;
    assign power   = lpmh_pkg::sat_power(quot);

endmodule

`default_nettype wire

// ===== rtl/lift_pid_move_and_hold_top.sv =====
// Top level of the lift PID move-and-hold controller: input register,
// phase control, state and result register. Depends on lpmh_pkg,
// lpmh_cfg_regs and lpmh_pid_calc.
`default_nettype none

// Each accepted word produces exactly one result word: it passes from the
// input register to the result register, and the block sustains one word
// per cycle while m_ready is high.
// The rate is set by the single registered pass through the PID datapath
// (three multipliers, the three-term sum and saturation) that also updates the
// controller state. Configuration writes take effect on the next edge and
// should be made only while no word is in flight.
module lift_pid_move_and_hold_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic        [lpmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [lpmh_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_func,
    input  wire logic        [lpmh_pkg::ANGLE_W-1:0]   s_angle,
    input  wire logic signed [lpmh_pkg::POS_W-1:0]     s_motor_position,
    input  wire logic                                s_autonomous,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [lpmh_pkg::POWER_W-1:0]   m_motor_power,
    output logic                                     m_drive,
    output logic             [lpmh_pkg::PHASE_W-1:0]   m_phase,
    output logic                                     m_rumble
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_HOLD = 2'd2
    } mode_t;

    localparam int SB = lpmh_pkg::SUM_BITS;
    localparam int PW = lpmh_pkg::POS_W;
    localparam logic [lpmh_pkg::TICK_W-1:0] TICK_MAX = '1;

    lpmh_pkg::cfg_t cfg;

    // input register
    logic                               in_valid_reg;
    logic                               func_reg;
    logic        [lpmh_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [PW-1:0]               pos_reg;
    logic                               auto_reg;

    // controller state
    mode_t                              mode_reg, mode_next;
    logic signed [lpmh_pkg::ERR_W-1:0]  last_error_reg, last_error_next;
    logic signed [SB-1:0]               error_sum_reg, error_sum_next;
    logic        [lpmh_pkg::TICK_W-1:0] tick_count_reg, tick_count_next;
    logic signed [PW-1:0]               hold_target_reg, hold_target_next;

    // result register
    logic                               out_valid_reg;
    logic signed [lpmh_pkg::POWER_W-1:0] power_reg, power_next;
    logic                               drive_reg, drive_next;
    logic        [lpmh_pkg::PHASE_W-1:0] phase_reg;
    logic                               rumble_reg, rumble_next;

    logic                               advance;
    logic signed [lpmh_pkg::ERR_W-1:0]  err;
    logic signed [SB-1:0]               sum_sat;
    logic signed [lpmh_pkg::POWER_W-1:0] pid_power;
    logic signed [lpmh_pkg::POWER_W-1:0] hold_power;
    logic signed [PW:0]                 hold_diff;
    logic        [lpmh_pkg::ERR_W-1:0]  err_mag;
    logic                               move_done;

    lpmh_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lpmh_pid_calc u_pid (
        .cfg        (cfg),
        .angle      (angle_reg),
        .last_error (last_error_reg),
        .error_sum  (error_sum_reg),
        .err        (err),
        .sum_sat    (sum_sat),
        .power      (pid_power)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign hold_diff  = $signed({hold_target_reg[PW-1], hold_target_reg})
                      - $signed({pos_reg[PW-1], pos_reg});
    assign hold_power = lpmh_pkg::sat_power(lpmh_pkg::ACC_W'(hold_diff));

    assign err_mag   = last_error_reg[lpmh_pkg::ERR_W-1] ? -last_error_reg : last_error_reg;
    assign move_done = (tick_count_reg >= cfg.tick_limit)
                    || (err_mag < {1'b0, cfg.settle_band});

    always_comb begin
        mode_next        = mode_reg;
        last_error_next  = last_error_reg;
        error_sum_next   = error_sum_reg;
        tick_count_next  = tick_count_reg;
        hold_target_next = hold_target_reg;
        power_next       = '0;
        drive_next       = 1'b0;
        rumble_next      = 1'b0;
        if (func_reg == lpmh_pkg::FUNC_START) begin
            rumble_next     = (mode_reg == MODE_HOLD);
            last_error_next = err;
            error_sum_next  = '0;
            tick_count_next = '0;
            mode_next       = MODE_MOVE;
        end else begin
            case (mode_reg)
                MODE_MOVE: begin
                    if (move_done) begin
                        hold_target_next = pos_reg;
                        mode_next        = MODE_HOLD;
                    end else begin
                        last_error_next = err;
                        error_sum_next  = sum_sat;
                        if (tick_count_reg != TICK_MAX) begin
                            tick_count_next = tick_count_reg + 1'b1;
                        end
                        power_next = pid_power;
                        drive_next = 1'b1;
                    end
                end
                MODE_HOLD: begin
                    if (auto_reg) begin
                        power_next = hold_power;
                        drive_next = 1'b1;
                    end else begin
                        mode_next   = MODE_IDLE;
                        rumble_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            last_error_reg  <= '0;
            error_sum_reg   <= '0;
            tick_count_reg  <= '0;
            hold_target_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                mode_reg        <= mode_next;
                last_error_reg  <= last_error_next;
                error_sum_reg   <= error_sum_next;
                tick_count_reg  <= tick_count_next;
                hold_target_reg <= hold_target_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            angle_reg <= s_angle;
            pos_reg   <= s_motor_position;
            auto_reg  <= s_autonomous;
        end
        if (advance) begin
            power_reg  <= power_next;
            drive_reg  <= drive_next;
            phase_reg  <= mode_next;
            rumble_reg <= rumble_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_motor_power = power_reg;
    assign m_drive       = drive_reg;
    assign m_phase       = phase_reg;
    assign m_rumble      = rumble_reg;

`ifndef SYNTHESIS
    a_idle_power_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drive |-> m_motor_power == '0)
        else $error("motor power nonzero without drive");

    a_drive_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive |-> m_phase != MODE_IDLE)
        else $error("drive asserted in idle phase");

    a_rumble_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rumble |-> !m_drive)
        else $error("rumble and drive in the same word");

    a_mode_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_reg))
        else $error("mode changed without a word advancing");
`endif

endmodule

`default_nettype wire
